// ===== hw/rtl/gaps_pkg.sv =====
// ----------------------------------------------------------------------------
// gaps_pkg
// Shared types and codes of the grid A* path search core.
// ----------------------------------------------------------------------------
package gaps_pkg;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  localparam logic [2:0] STS_WRITTEN  = 3'd0;
  localparam logic [2:0] STS_FOUND    = 3'd1;
  localparam logic [2:0] STS_NO_PATH  = 3'd2;
  localparam logic [2:0] STS_OVERFLOW = 3'd3;
  localparam logic [2:0] STS_BEYOND   = 3'd4;

  localparam logic [1:0] DIR_ROW_INC = 2'd0;
  localparam logic [1:0] DIR_ROW_DEC = 2'd1;
  localparam logic [1:0] DIR_COL_INC = 2'd2;
  localparam logic [1:0] DIR_COL_DEC = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  row_coord;
    logic [5:0]  col_coord;
    logic        blocked;
    logic [5:0]  goal_row;
    logic [5:0]  goal_col;
    logic [11:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] path_length;
    logic [5:0]  step_row;
    logic [5:0]  step_col;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_MAP,
    ST_RDQ,
    ST_CLEAR,
    ST_PUSH,
    ST_PUP,
    ST_PUPC,
    ST_POP,
    ST_POP1,
    ST_POP2,
    ST_SD,
    ST_SDL,
    ST_SDR,
    ST_SDW,
    ST_EXP,
    ST_NB,
    ST_NBC,
    ST_LINK,
    ST_NXT,
    ST_RB0,
    ST_RB1,
    ST_RB2,
    ST_RB3,
    ST_DONE
  } gaps_state_t;

endpackage

// ===== hw/rtl/grid_astar_path_search_core.sv =====
// ----------------------------------------------------------------------------
// grid_astar_path_search_core
// Four-connected A* search over a square occupancy map with a binary open heap.
// ----------------------------------------------------------------------------
// One item at a time. After reset all 2**(2*ceil(log2 GRID_DIM)) map cells (4096
// at the defaults) are swept clear before the first item is taken. A search first
// clears the closed and parent flags, then runs on one heap memory with one read and
// one write port: a push climbs the heap level by level, a pop sinks it level by
// level, the four neighbors are checked in turn, and the path is rebuilt step by
// step. Cells are stored as {row, col}; the heap holds HEAP_DEPTH entries.
module grid_astar_path_search_core #(
  parameter int GRID_DIM   = 64,
  parameter int HEAP_DEPTH = 16384
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gaps_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output gaps_pkg::out_item_t out_item
);
  import gaps_pkg::*;

  localparam int AW    = $clog2(GRID_DIM);
  localparam int CIW   = 2 * AW;
  localparam int NCELL = 1 << CIW;
  localparam int LENW  = CIW + 1;
  localparam int HAW   = $clog2(HEAP_DEPTH);
  localparam int CNTW  = $clog2(HEAP_DEPTH + 1);
  localparam int CRW   = (AW > 6) ? AW : 6;
  localparam int GW    = CIW + 8;
  localparam int FW    = GW + 1;
  localparam int SEQW  = 32;

  typedef struct packed {
    logic [FW-1:0]   f;
    logic [GW-1:0]   g;
    logic [CIW-1:0]  cidx;
    logic [SEQW-1:0] seq;
  } entry_t;

  function automatic logic goes_first(input entry_t a, input entry_t b);
    goes_first = (a.f != b.f) ? (a.f < b.f) : (a.seq > b.seq);
  endfunction

  function automatic logic [CRW-1:0] cdiff(input logic [CRW-1:0] a, input logic [CRW-1:0] b);
    cdiff = (a > b) ? a - b : b - a;
  endfunction

  logic            map_mem   [NCELL];
  logic            cl_mem    [NCELL];
  logic            pk_mem    [NCELL];
  logic [CIW-1:0]  par_mem   [NCELL];
  logic [CIW-1:0]  path_mem  [NCELL];
  entry_t          heap_mem  [HEAP_DEPTH];

  gaps_state_t     state_r, state_nxt;
  logic [LENW-1:0] ctr_r, ctr_nxt;
  in_item_t        item_r, item_nxt;
  logic [CIW-1:0]  cur_r, cur_nxt;
  logic [GW-1:0]   curg_r, curg_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic [CIW-1:0]  nb_r, nb_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [SEQW-1:0] seq_r, seq_nxt;
  entry_t          ent_r, ent_nxt;
  logic [HAW-1:0]  idx_r, idx_nxt;
  logic [HAW-1:0]  par_r, par_nxt;
  entry_t          last_r, last_nxt;
  logic [HAW-1:0]  best_r, best_nxt;
  entry_t          beste_r, beste_nxt;
  logic            exp_r, exp_nxt;
  logic [CIW-1:0]  walk_r, walk_nxt;
  logic [LENW-1:0] n_r, n_nxt;
  logic [LENW-1:0] plen_r, plen_nxt;
  logic [2:0]      rsts_r, rsts_nxt;
  logic [5:0]      rrow_r, rrow_nxt;
  logic [5:0]      rcol_r, rcol_nxt;
  logic            ovld_r, ovld_nxt;
  out_item_t       oitem_r, oitem_nxt;

  entry_t          hrd_r;
  logic            map_q_r, cl_q_r, pk_q_r;
  logic [CIW-1:0]  par_q_r, path_q_r;

  logic            h_we;
  logic [HAW-1:0]  h_wa, h_ra;
  entry_t          h_wd;
  logic [CIW-1:0]  c_ra, pa_ra;
  logic            map_we, map_wd, cl_we, cl_wd, pk_we, pk_wd, pr_we, pa_we;
  logic [CIW-1:0]  map_wa, cl_wa, pk_wa, pr_wa, pr_wd, pa_wa, pa_wd;

  logic [AW-1:0]   rcur, ccur, nr, nc;
  logic            nb_ok;
  logic [AW:0]     rinc, cinc;
  logic [CRW-1:0]  gr_x, gc_x;
  logic [FW-1:0]   nb_f, st_f;
  logic [HAW:0]    lw, rw;
  logic            l_ok, r_ok;
  logic            st_ongrid;
  gaps_state_t     push_done;
  logic [11:0]     plen_sat;

  assign rcur = cur_r[CIW-1:AW];
  assign ccur = cur_r[AW-1:0];
  assign rinc = {1'b0, rcur} + (AW+1)'(1);
  assign cinc = {1'b0, ccur} + (AW+1)'(1);
  assign gr_x = CRW'(item_r.goal_row);
  assign gc_x = CRW'(item_r.goal_col);
  assign lw   = {idx_r, 1'b1};
  assign rw   = lw + (HAW+1)'(1);
  assign l_ok = (CNTW+HAW+1)'(lw) < (CNTW+HAW+1)'(cnt_r);
  assign r_ok = (CNTW+HAW+1)'(rw) < (CNTW+HAW+1)'(cnt_r);
  assign st_f = FW'(cdiff(CRW'(item_r.row_coord), gr_x)) + FW'(cdiff(CRW'(item_r.col_coord), gc_x));
  assign nb_f = FW'(curg_r) + FW'(1) + FW'(cdiff(CRW'(nr), gr_x)) + FW'(cdiff(CRW'(nc), gc_x));
  assign push_done = exp_r ? ST_LINK : ST_POP;
  assign st_ongrid = ((CRW+1)'(in_item.row_coord) < (CRW+1)'(GRID_DIM)) &&
                     ((CRW+1)'(in_item.col_coord) < (CRW+1)'(GRID_DIM));
  assign plen_sat = ((LENW+12)'(plen_r) > (LENW+12)'(4095)) ? 12'd4095 : 12'(plen_r);

  always_comb begin
    nr = rcur;
    nc = ccur;
    nb_ok = 1'b0;
    case (dir_r)
      DIR_ROW_INC: begin
        nr = AW'(rinc);
        nb_ok = rinc < (AW+1)'(GRID_DIM);
      end
      DIR_ROW_DEC: begin
        nr = rcur - AW'(1);
        nb_ok = rcur != '0;
      end
      DIR_COL_INC: begin
        nc = AW'(cinc);
        nb_ok = cinc < (AW+1)'(GRID_DIM);
      end
      DIR_COL_DEC: begin
        nc = ccur - AW'(1);
        nb_ok = ccur != '0;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SWEEP;
      ctr_r   <= '0;
      cnt_r   <= '0;
      seq_r   <= '0;
      plen_r  <= '0;
      ovld_r  <= 1'b0;
      exp_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctr_r   <= ctr_nxt;
      cnt_r   <= cnt_nxt;
      seq_r   <= seq_nxt;
      plen_r  <= plen_nxt;
      ovld_r  <= ovld_nxt;
      exp_r   <= exp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r  <= item_nxt;
    cur_r   <= cur_nxt;
    curg_r  <= curg_nxt;
    dir_r   <= dir_nxt;
    nb_r    <= nb_nxt;
    ent_r   <= ent_nxt;
    idx_r   <= idx_nxt;
    par_r   <= par_nxt;
    last_r  <= last_nxt;
    best_r  <= best_nxt;
    beste_r <= beste_nxt;
    walk_r  <= walk_nxt;
    n_r     <= n_nxt;
    rsts_r  <= rsts_nxt;
    rrow_r  <= rrow_nxt;
    rcol_r  <= rcol_nxt;
    oitem_r <= oitem_nxt;
  end

  always_ff @(posedge clk) begin
    if (h_we) heap_mem[h_wa] <= h_wd;
    hrd_r <= heap_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (cl_we) cl_mem[cl_wa] <= cl_wd;
    if (pk_we) pk_mem[pk_wa] <= pk_wd;
    if (pr_we) par_mem[pr_wa] <= pr_wd;
    map_q_r <= map_mem[c_ra];
    cl_q_r  <= cl_mem[c_ra];
    pk_q_r  <= pk_mem[c_ra];
    par_q_r <= par_mem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (pa_we) path_mem[pa_wa] <= pa_wd;
    path_q_r <= path_mem[pa_ra];
  end

  always_comb begin
    state_nxt = state_r;
    ctr_nxt   = ctr_r;
    item_nxt  = item_r;
    cur_nxt   = cur_r;
    curg_nxt  = curg_r;
    dir_nxt   = dir_r;
    nb_nxt    = nb_r;
    cnt_nxt   = cnt_r;
    seq_nxt   = seq_r;
    ent_nxt   = ent_r;
    idx_nxt   = idx_r;
    par_nxt   = par_r;
    last_nxt  = last_r;
    best_nxt  = best_r;
    beste_nxt = beste_r;
    exp_nxt   = exp_r;
    walk_nxt  = walk_r;
    n_nxt     = n_r;
    plen_nxt  = plen_r;
    rsts_nxt  = rsts_r;
    rrow_nxt  = rrow_r;
    rcol_nxt  = rcol_r;
    ovld_nxt  = ovld_r && out_stall;
    oitem_nxt = oitem_r;
    h_we   = 1'b0;
    h_wa   = idx_r;
    h_wd   = ent_r;
    h_ra   = '0;
    c_ra   = cur_r;
    pa_ra  = CIW'(item_r.step_index);
    map_we = 1'b0;
    map_wa = CIW'(ctr_r);
    map_wd = 1'b0;
    cl_we  = 1'b0;
    cl_wa  = CIW'(ctr_r);
    cl_wd  = 1'b0;
    pk_we  = 1'b0;
    pk_wa  = CIW'(ctr_r);
    pk_wd  = 1'b0;
    pr_we  = 1'b0;
    pr_wa  = nb_r;
    pr_wd  = cur_r;
    pa_we  = 1'b0;
    pa_wa  = CIW'(n_r - LENW'(1));
    pa_wd  = walk_r;
    in_stall = (state_r != ST_IDLE);

    case (state_r)
      ST_SWEEP: begin
        map_we  = 1'b1;
        ctr_nxt = ctr_r + LENW'(1);
        if (ctr_r == LENW'(NCELL - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        pa_ra = CIW'(in_item.step_index);
        if (in_valid) begin
          item_nxt = in_item;
          rsts_nxt = STS_WRITTEN;
          rrow_nxt = '0;
          rcol_nxt = '0;
          case (in_item.cmd)
            CMD_WRITE: state_nxt = ST_MAP;
            CMD_SEARCH: begin
              plen_nxt = '0;
              ctr_nxt  = '0;
              cnt_nxt  = '0;
              seq_nxt  = '0;
              if (st_ongrid) begin
                state_nxt = ST_CLEAR;
              end else begin
                rsts_nxt  = STS_NO_PATH;
                state_nxt = ST_DONE;
              end
            end
            CMD_READ: state_nxt = ST_RDQ;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_MAP: begin
        map_wa = {AW'(item_r.row_coord), AW'(item_r.col_coord)};
        map_wd = item_r.blocked;
        map_we = ((CRW+1)'(item_r.row_coord) < (CRW+1)'(GRID_DIM)) &&
                 ((CRW+1)'(item_r.col_coord) < (CRW+1)'(GRID_DIM));
        state_nxt = ST_DONE;
      end
      ST_RDQ: begin
        if ((LENW+12)'(item_r.step_index) < (LENW+12)'(plen_r)) begin
          rsts_nxt = STS_FOUND;
          rrow_nxt = 6'(path_q_r[CIW-1:AW]);
          rcol_nxt = 6'(path_q_r[AW-1:0]);
        end else begin
          rsts_nxt = STS_BEYOND;
        end
        state_nxt = ST_DONE;
      end
      ST_CLEAR: begin
        cl_we   = 1'b1;
        pk_we   = 1'b1;
        ctr_nxt = ctr_r + LENW'(1);
        if (ctr_r == LENW'(NCELL - 1)) begin
          ent_nxt.f    = st_f;
          ent_nxt.g    = '0;
          ent_nxt.cidx = {AW'(item_r.row_coord), AW'(item_r.col_coord)};
          exp_nxt      = 1'b0;
          state_nxt    = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (cnt_r == CNTW'(HEAP_DEPTH)) begin
          plen_nxt  = '0;
          rsts_nxt  = STS_OVERFLOW;
          state_nxt = ST_DONE;
        end else begin
          ent_nxt.seq = seq_r;
          seq_nxt     = seq_r + SEQW'(1);
          idx_nxt     = HAW'(cnt_r);
          cnt_nxt     = cnt_r + CNTW'(1);
          state_nxt   = ST_PUP;
        end
      end
      ST_PUP: begin
        h_ra    = (idx_r - HAW'(1)) >> 1;
        par_nxt = (idx_r - HAW'(1)) >> 1;
        if (idx_r == '0) begin
          h_we      = 1'b1;
          state_nxt = push_done;
        end else begin
          state_nxt = ST_PUPC;
        end
      end
      ST_PUPC: begin
        h_we = 1'b1;
        if (goes_first(ent_r, hrd_r)) begin
          h_wd      = hrd_r;
          idx_nxt   = par_r;
          state_nxt = ST_PUP;
        end else begin
          state_nxt = push_done;
        end
      end
      ST_POP: begin
        if (cnt_r == '0) begin
          plen_nxt  = '0;
          rsts_nxt  = STS_NO_PATH;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt   = cnt_r - CNTW'(1);
          state_nxt = ST_POP1;
        end
      end
      ST_POP1: begin
        cur_nxt  = hrd_r.cidx;
        curg_nxt = hrd_r.g;
        h_ra     = HAW'(cnt_r);
        state_nxt = (cnt_r == '0) ? ST_EXP : ST_POP2;
      end
      ST_POP2: begin
        last_nxt  = hrd_r;
        idx_nxt   = '0;
        state_nxt = ST_SD;
      end
      ST_SD: begin
        h_ra = HAW'(lw);
        if (l_ok) begin
          state_nxt = ST_SDL;
        end else begin
          h_we      = 1'b1;
          h_wd      = last_r;
          state_nxt = ST_EXP;
        end
      end
      ST_SDL: begin
        h_ra = HAW'(rw);
        if (goes_first(hrd_r, last_r)) begin
          best_nxt  = HAW'(lw);
          beste_nxt = hrd_r;
        end else begin
          best_nxt  = idx_r;
          beste_nxt = last_r;
        end
        state_nxt = r_ok ? ST_SDR : ST_SDW;
      end
      ST_SDR: begin
        if (goes_first(hrd_r, beste_r)) begin
          best_nxt  = HAW'(rw);
          beste_nxt = hrd_r;
        end
        state_nxt = ST_SDW;
      end
      ST_SDW: begin
        h_we = 1'b1;
        if (best_r == idx_r) begin
          h_wd      = last_r;
          state_nxt = ST_EXP;
        end else begin
          h_wd      = beste_r;
          idx_nxt   = best_r;
          state_nxt = ST_SD;
        end
      end
      ST_EXP: begin
        if ((CRW'(rcur) == gr_x) && (CRW'(ccur) == gc_x)) begin
          state_nxt = ST_RB0;
        end else begin
          cl_we     = 1'b1;
          cl_wa     = cur_r;
          cl_wd     = 1'b1;
          dir_nxt   = DIR_ROW_INC;
          state_nxt = ST_NB;
        end
      end
      ST_NB: begin
        c_ra   = {nr, nc};
        nb_nxt = {nr, nc};
        ent_nxt.f    = nb_f;
        ent_nxt.g    = curg_r + GW'(1);
        ent_nxt.cidx = {nr, nc};
        state_nxt = nb_ok ? ST_NBC : ST_NXT;
      end
      ST_NBC: begin
        if (!map_q_r && !cl_q_r) begin
          exp_nxt   = 1'b1;
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_NXT;
        end
      end
      ST_LINK: begin
        pr_we     = 1'b1;
        pk_we     = 1'b1;
        pk_wa     = nb_r;
        pk_wd     = 1'b1;
        state_nxt = ST_NXT;
      end
      ST_NXT: begin
        dir_nxt   = dir_r + 2'd1;
        state_nxt = (dir_r == DIR_COL_DEC) ? ST_POP : ST_NB;
      end
      ST_RB0: begin
        c_ra      = cur_r;
        n_nxt     = '0;
        state_nxt = ST_RB1;
      end
      ST_RB1: begin
        c_ra = par_q_r;
        if (pk_q_r && (n_r < LENW'(NCELL))) begin
          n_nxt = n_r + LENW'(1);
        end else begin
          plen_nxt  = n_r;
          walk_nxt  = cur_r;
          state_nxt = ST_RB2;
        end
      end
      ST_RB2: begin
        c_ra = walk_r;
        if (n_r == '0) begin
          rsts_nxt  = STS_FOUND;
          state_nxt = ST_DONE;
        end else begin
          pa_we     = 1'b1;
          n_nxt     = n_r - LENW'(1);
          state_nxt = ST_RB3;
        end
      end
      ST_RB3: begin
        walk_nxt  = par_q_r;
        state_nxt = ST_RB2;
      end
      ST_DONE: begin
        if (!ovld_r || !out_stall) begin
          ovld_nxt              = 1'b1;
          oitem_nxt.status      = rsts_r;
          oitem_nxt.path_length = plen_sat;
          oitem_nxt.step_row    = rrow_r;
          oitem_nxt.step_col    = rcol_r;
          state_nxt             = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_valid = ovld_r;
  assign out_item  = oitem_r;

  a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNTW'(HEAP_DEPTH))
    else $error("heap count beyond depth");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    plen_r <= LENW'(NCELL))
    else $error("path length beyond cell count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP1) |-> ($past(cnt_r) != '0))
    else $error("pop from empty heap");

endmodule
